### hdl/dthc_pkg.sv
`timescale 1ns / 1ps
package dthc_pkg;

   localparam int DEPTH_BITS = 16;
   localparam int FRAC_BITS  = 17;
   localparam logic [15:0] DEPTH_MASK = 16'((32'd1 << DEPTH_BITS) - 32'd1);

   localparam logic [2:0] REG_RANGE_MIN   = 3'd0;
   localparam logic [2:0] REG_RANGE_MAX   = 3'd1;
   localparam logic [2:0] REG_HUE_NEAR    = 3'd2;
   localparam logic [2:0] REG_HUE_FAR     = 3'd3;
   localparam logic [2:0] REG_SATURATION  = 3'd4;
   localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;
   localparam logic [2:0] REG_OUTPUT_MODE = 3'd6;

   localparam logic [10:0] HUE_WRAP = 11'd1536;

   typedef struct packed {
      logic        last;
      logic        invalid;
      logic        mono;
      logic [15:0] depth;
   } side_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] quo;
      logic [15:0] den;
      side_type    side;
   } div_type;

   typedef struct packed {
      logic [10:0] hue_near;
      logic [10:0] hue_far;
      logic [16:0] chroma;
      logic [16:0] offset;
   } color_cfg_type;

endpackage

### hdl/dthc_div_cell.sv
`timescale 1ns / 1ps
module dthc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  dthc_pkg::div_type data_in,
   output logic              valid_out,
   output dthc_pkg::div_type data_out
);
   logic              valid_ff;
   dthc_pkg::div_type data_ff;
   dthc_pkg::div_type data_in_next;
   logic              fits;
   logic [16:0]       rem_sub;

   always_comb begin
      fits    = data_in.rem >= {1'b0, data_in.den};
      rem_sub = fits ? (data_in.rem - {1'b0, data_in.den}) : data_in.rem;
      data_in_next      = data_in;
      data_in_next.quo  = {data_in.quo[15:0], fits};
      data_in_next.rem  = {rem_sub[15:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule

### hdl/dthc_color.sv
`timescale 1ns / 1ps
module dthc_color (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_in,
   input  logic [16:0]             frac_in,
   input  dthc_pkg::side_type      side_in,
   input  dthc_pkg::color_cfg_type cfg,
   output logic                    valid_out,
   output logic [7:0]              red,
   output logic [7:0]              green,
   output logic [7:0]              blue,
   output logic [7:0]              alpha,
   output logic [15:0]             mono_value,
   output logic                    range_invalid,
   output logic                    last_pixel
);
   logic [3:0]          valid_ff;
   dthc_pkg::side_type  side1_ff, side2_ff, side3_ff;
   logic signed [30:0]  prod_ff;
   logic signed [30:0]  prod_in;
   logic [10:0]         hue_raw, hue;
   logic [2:0]          sector_ff, sector3_ff;
   logic [8:0]          weight_ff;
   logic [17:0]         x_ff;
   logic [25:0]         x_full;
   logic [17:0]         rr, gg, bb;
   logic [7:0]          red_ff, green_ff, blue_ff, alpha_ff;
   logic [15:0]         mono_ff;
   logic                inv_ff, last_ff;

   function automatic logic [7:0] to_chan(input logic [17:0] v);
      return (v[17:16] != 2'b00) ? 8'hff : v[15:8];
   endfunction

   assign prod_in = $signed({1'b0, frac_in}) *
                    ($signed({1'b0, cfg.hue_far}) - $signed({1'b0, cfg.hue_near}));
   assign hue_raw = 11'($signed({1'b0, cfg.hue_near}) + (prod_ff >>> 16));
   assign hue     = (hue_raw >= dthc_pkg::HUE_WRAP) ? hue_raw - dthc_pkg::HUE_WRAP : hue_raw;
   assign x_full  = cfg.chroma * weight_ff;

   always_comb begin
      case (sector3_ff)
         3'd0:    begin rr = {1'b0, cfg.chroma}; gg = x_ff; bb = 18'd0; end
         3'd1:    begin rr = x_ff; gg = {1'b0, cfg.chroma}; bb = 18'd0; end
         3'd2:    begin rr = 18'd0; gg = {1'b0, cfg.chroma}; bb = x_ff; end
         3'd3:    begin rr = 18'd0; gg = x_ff; bb = {1'b0, cfg.chroma}; end
         3'd4:    begin rr = x_ff; gg = 18'd0; bb = {1'b0, cfg.chroma}; end
         default: begin rr = {1'b0, cfg.chroma}; gg = 18'd0; bb = x_ff; end
      endcase
      rr = rr + {1'b0, cfg.offset};
      gg = gg + {1'b0, cfg.offset};
      bb = bb + {1'b0, cfg.offset};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
      if (advance) begin
         prod_ff    <= prod_in;
         side1_ff   <= side_in;
         sector_ff  <= hue[10:8];
         weight_ff  <= hue[8] ? 9'd256 - {1'b0, hue[7:0]} : {1'b0, hue[7:0]};
         side2_ff   <= side1_ff;
         x_ff       <= x_full[25:8];
         sector3_ff <= sector_ff;
         side3_ff   <= side2_ff;
         inv_ff     <= side3_ff.invalid;
         last_ff    <= side3_ff.last;
         if (side3_ff.mono) begin
            red_ff   <= 8'd0;
            green_ff <= 8'd0;
            blue_ff  <= 8'd0;
            alpha_ff <= 8'd0;
            mono_ff  <= side3_ff.depth;
         end else begin
            red_ff   <= to_chan(rr);
            green_ff <= to_chan(gg);
            blue_ff  <= to_chan(bb);
            alpha_ff <= 8'hff;
            mono_ff  <= 16'd0;
         end
      end
   end

   assign valid_out     = valid_ff[3];
   assign red           = red_ff;
   assign green         = green_ff;
   assign blue          = blue_ff;
   assign alpha         = alpha_ff;
   assign mono_value    = mono_ff;
   assign range_invalid = inv_ff;
   assign last_pixel    = last_ff;
endmodule

### hdl/depth_to_hsv_colormap.sv
`timescale 1ns / 1ps
// Pipeline: input register, 17 divider cells and 4 color stages, the last of which
// is the output register; rsp_valid rises when a req transaction leaves it.
// Throughput: one pixel per cycle; the whole pipeline holds while rsp_stall is
// high with a result waiting.
// Reset: synchronous, clears the pipeline valids and loads register defaults.
module depth_to_hsv_colormap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_depth,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [15:0] rsp_mono_value,
   output logic        rsp_range_invalid,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int NCELL = dthc_pkg::FRAC_BITS;

   logic [15:0] range_min_ff, range_max_ff;
   logic [10:0] hue_near_ff, hue_far_ff;
   logic [8:0]  sat_ff, bright_ff;
   logic        mode_ff;
   logic [8:0]  sat_c, bright_c;
   logic [16:0] chroma_ff, offset_ff;
   dthc_pkg::color_cfg_type cfg;

   logic        advance;
   logic        s0_valid_ff;
   dthc_pkg::div_type s0_ff, s0_in;
   logic [15:0] depth_m, dc;
   logic        invalid;

   logic              cell_valid [NCELL+1];
   dthc_pkg::div_type cell_data  [NCELL+1];

   assign csr_ready = 1'b1;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= 16'd0;
         range_max_ff <= 16'd4095;
         hue_near_ff  <= 11'd0;
         hue_far_ff   <= 11'd1173;
         sat_ff       <= 9'd256;
         bright_ff    <= 9'd256;
         mode_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            dthc_pkg::REG_RANGE_MIN:   range_min_ff <= csr_data;
            dthc_pkg::REG_RANGE_MAX:   range_max_ff <= csr_data;
            dthc_pkg::REG_HUE_NEAR:    hue_near_ff  <= csr_data[10:0];
            dthc_pkg::REG_HUE_FAR:     hue_far_ff   <= csr_data[10:0];
            dthc_pkg::REG_SATURATION:  sat_ff       <= csr_data[8:0];
            dthc_pkg::REG_BRIGHTNESS:  bright_ff    <= csr_data[8:0];
            dthc_pkg::REG_OUTPUT_MODE: mode_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign sat_c    = (sat_ff > 9'd256) ? 9'd256 : sat_ff;
   assign bright_c = (bright_ff > 9'd256) ? 9'd256 : bright_ff;

   always_ff @(posedge clock) begin
      chroma_ff <= 17'(sat_c * bright_c);
      offset_ff <= 17'({bright_c, 8'd0}) - 17'(sat_c * bright_c);
   end

   assign cfg = '{hue_near: hue_near_ff, hue_far: hue_far_ff,
                  chroma: chroma_ff, offset: offset_ff};

   always_comb begin
      depth_m = req_depth & dthc_pkg::DEPTH_MASK;
      invalid = range_max_ff <= range_min_ff;
      dc      = depth_m;
      if (dc < range_min_ff) dc = range_min_ff;
      if (dc > range_max_ff) dc = range_max_ff;
      s0_in.rem = invalid ? 17'd0 : {1'b0, dc - range_min_ff};
      s0_in.den = invalid ? 16'd1 : range_max_ff - range_min_ff;
      s0_in.quo = 17'd0;
      s0_in.side.last    = req_frame_end;
      s0_in.side.invalid = invalid;
      s0_in.side.mono    = mode_ff;
      s0_in.side.depth   = depth_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_ff <= s0_in;
      end
   end

   assign cell_valid[0] = s0_valid_ff;
   assign cell_data[0]  = s0_ff;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      dthc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (cell_valid[i]),
         .data_in   (cell_data[i]),
         .valid_out (cell_valid[i+1]),
         .data_out  (cell_data[i+1])
      );
   end

   dthc_color u_color (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .valid_in      (cell_valid[NCELL]),
      .frac_in       (cell_data[NCELL].quo),
      .side_in       (cell_data[NCELL].side),
      .cfg           (cfg),
      .valid_out     (rsp_valid),
      .red           (rsp_red),
      .green         (rsp_green),
      .blue          (rsp_blue),
      .alpha         (rsp_alpha),
      .mono_value    (rsp_mono_value),
      .range_invalid (rsp_range_invalid),
      .last_pixel    (rsp_last_pixel)
   );

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to output backpressure");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s0_valid_ff)
      else $error("accepted transaction missing from input stage");

   a_mono_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alpha == 8'd0) |->
         (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("mono transaction carries color data");
endmodule

### sim/depth_to_hsv_colormap_checker.sv
`timescale 1ns / 1ps
module depth_to_hsv_colormap_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_depth,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha,
   input  logic [15:0] rsp_mono_value,
   input  logic        rsp_range_invalid,
   input  logic        rsp_last_pixel,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] mono;
      logic        invalid;
      logic        last;
   } pixel_type;

   logic [15:0] cfg_min, cfg_max;
   logic [10:0] cfg_hue_near, cfg_hue_far;
   logic [8:0]  cfg_sat, cfg_bright;
   logic        cfg_mono;

   pixel_type expected_pixels[$];

   function automatic int unsigned to_channel(int unsigned v);
      return (v >> 8) > 255 ? 255 : (v >> 8);
   endfunction

   function automatic pixel_type colorize(logic [15:0] depth, logic frame_end);
      pixel_type p;
      longint unsigned frac, hue;
      int unsigned dc, sector, f, s, v, c, m, w, x, rr, gg, bb;
      p = '0;
      p.last = frame_end;
      p.invalid = (cfg_max <= cfg_min);
      dc = depth & dthc_pkg::DEPTH_MASK;
      if (cfg_mono) begin
         p.mono = dc[15:0];
         return p;
      end
      frac = 0;
      if (!p.invalid) begin
         if (dc < cfg_min) dc = cfg_min;
         if (dc > cfg_max) dc = cfg_max;
         frac = (longint'(dc - cfg_min) * 65536) / longint'(cfg_max - cfg_min);
      end
      hue = (frac * cfg_hue_far + (65536 - frac) * cfg_hue_near) >> 16;
      if (hue >= dthc_pkg::HUE_WRAP) hue -= dthc_pkg::HUE_WRAP;
      sector = hue >> 8;
      f = hue & 255;
      s = cfg_sat > 256 ? 256 : cfg_sat;
      v = cfg_bright > 256 ? 256 : cfg_bright;
      c = s * v;
      m = v * 256 - c;
      w = sector[0] ? 256 - f : f;
      x = (c * w) >> 8;
      case (sector)
         0: begin rr = c; gg = x; bb = 0; end
         1: begin rr = x; gg = c; bb = 0; end
         2: begin rr = 0; gg = c; bb = x; end
         3: begin rr = 0; gg = x; bb = c; end
         4: begin rr = x; gg = 0; bb = c; end
         default: begin rr = c; gg = 0; bb = x; end
      endcase
      p.red   = to_channel(rr + m);
      p.green = to_channel(gg + m);
      p.blue  = to_channel(bb + m);
      p.alpha = 8'hff;
      return p;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending = expected_pixels.size();

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         cfg_min <= 16'd0;
         cfg_max <= 16'd4095;
         cfg_hue_near <= 11'd0;
         cfg_hue_far <= 11'd1173;
         cfg_sat <= 9'd256;
         cfg_bright <= 9'd256;
         cfg_mono <= 1'b0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dthc_pkg::REG_RANGE_MIN:   cfg_min <= csr_data;
               dthc_pkg::REG_RANGE_MAX:   cfg_max <= csr_data;
               dthc_pkg::REG_HUE_NEAR:    cfg_hue_near <= csr_data[10:0];
               dthc_pkg::REG_HUE_FAR:     cfg_hue_far <= csr_data[10:0];
               dthc_pkg::REG_SATURATION:  cfg_sat <= csr_data[8:0];
               dthc_pkg::REG_BRIGHTNESS:  cfg_bright <= csr_data[8:0];
               dthc_pkg::REG_OUTPUT_MODE: cfg_mono <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(colorize(req_depth, req_frame_end));
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected transaction", 1, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red != want.red) report("red", rsp_red, want.red);
               if (rsp_green != want.green) report("green", rsp_green, want.green);
               if (rsp_blue != want.blue) report("blue", rsp_blue, want.blue);
               if (rsp_alpha != want.alpha) report("alpha", rsp_alpha, want.alpha);
               if (rsp_mono_value != want.mono)
                  report("mono_value", rsp_mono_value, want.mono);
               if (rsp_range_invalid != want.invalid)
                  report("range_invalid", rsp_range_invalid, want.invalid);
               if (rsp_last_pixel != want.last)
                  report("last_pixel", rsp_last_pixel, want.last);
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

### sim/depth_to_hsv_colormap_tb.sv
`timescale 1ns / 1ps
module depth_to_hsv_colormap_tb;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_depth = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic [15:0] rsp_mono_value;
   logic        rsp_range_invalid, rsp_last_pixel;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int   fail_count, pending;
   bit   calm = 1'b0;
   int   stall_left = 0;
   int   free_left = 0;
   int   lo_depth = 0, hi_depth = 4095;

   depth_to_hsv_colormap i_dut (.*);

   depth_to_hsv_colormap_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left <= $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         free_left <= $urandom_range(1, 40);
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_pixel(logic [15:0] depth, logic frame_end);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_depth <= depth;
      req_frame_end <= frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] rmin, logic [15:0] rmax, logic [15:0] hn,
                             logic [15:0] hf, logic [15:0] sat, logic [15:0] bri,
                             logic mono);
      logic [15:0] vals[7];
      logic [2:0]  order[8];
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      vals = '{rmin, rmax, hn, hf, sat, bri, {15'($urandom), mono}};
      order = '{3'd7, dthc_pkg::REG_RANGE_MIN, dthc_pkg::REG_RANGE_MAX,
                dthc_pkg::REG_HUE_NEAR, dthc_pkg::REG_HUE_FAR,
                dthc_pkg::REG_SATURATION, dthc_pkg::REG_BRIGHTNESS,
                dthc_pkg::REG_OUTPUT_MODE};
      foreach (order[k]) begin
         csr_valid <= 1'b1;
         csr_index <= order[k];
         csr_data <= (order[k] == 3'd7) ? 16'($urandom) : vals[order[k]];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      lo_depth = rmin;
      hi_depth = rmax;
   endtask

   task automatic run_pixels(int count);
      logic [15:0] d;
      int lo, hi;
      lo = lo_depth < hi_depth ? lo_depth : hi_depth;
      hi = lo_depth < hi_depth ? hi_depth : lo_depth;
      send_pixel(16'(lo), 1'b0);
      send_pixel(16'(hi), 1'b1);
      send_pixel(16'(lo - 1), 1'b0);
      send_pixel(16'(hi + 1), 1'b0);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1:    d = 16'($urandom);
            2:       d = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: d = 16'($urandom_range(lo, hi));
         endcase
         send_pixel(d, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // power-on settings, directed corners
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hffff, 1'b1);
      send_pixel(16'd4095, 1'b0);
      send_pixel(16'd4096, 1'b0);
      send_pixel(16'd2048, 1'b1);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'haaaa, 1'b0);
      run_pixels(120);
      // empty range, wrapping hue, oversized brightness
      write_regs(16'd1000, 16'd1000, 16'hf7ff, 16'h0000, 16'hfeff, 16'h01ff, 1'b0);
      run_pixels(60);
      // inverted range, black
      write_regs(16'd60000, 16'd100, 16'd1535, 16'd1535, 16'd0, 16'd0, 1'b0);
      run_pixels(60);
      write_regs(16'd0, 16'd65535, 16'd0, 16'd1535, 16'd256, 16'd256, 1'b0);
      run_pixels(200);
      write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 1'b1);
      run_pixels(160);
      write_regs(16'd65534, 16'd65535, 16'd1800, 16'd2047, 16'd300, 16'd128, 1'b0);
      run_pixels(120);
      write_regs(16'd1535, 16'd65535, 16'd2047, 16'd1536, 16'd256, 16'd200, 1'b0);
      run_pixels(160);
      repeat (4) begin
         logic [15:0] a;
         a = 16'($urandom_range(0, 60000));
         write_regs(a, 16'($urandom_range(a + 1, 65535)), 16'($urandom_range(0, 2047)),
                    16'($urandom_range(0, 2047)), 16'($urandom_range(0, 300)),
                    16'($urandom_range(0, 300)), 1'b0);
         run_pixels(160);
      end
      calm = 1'b1;
      write_regs(16'd200, 16'd9000, 16'd100, 16'd1400, 16'd256, 16'd256, 1'b0);
      run_pixels(140);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hdl/dthc_pkg.sv
hdl/dthc_div_cell.sv
hdl/dthc_color.sv
hdl/depth_to_hsv_colormap.sv
sim/depth_to_hsv_colormap_checker.sv
sim/depth_to_hsv_colormap_tb.sv
